>>> hw/rtl/depq_pkg.sv
package depq_pkg;

  localparam int KEY_W = 32;

  localparam logic [1:0] KIND_INSERT     = 2'd0;
  localparam logic [1:0] KIND_REMOVE_MAX = 2'd1;
  localparam logic [1:0] KIND_REMOVE_MIN = 2'd2;

  localparam logic [1:0] STATUS_REMOVED  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP_FRONT,
    OP_POP_BACK
  } op_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    occ;
    logic                    beyond;
  } link_t;

endpackage

>>> hw/rtl/double_ended_priority_queue_unit.sv
// Double-ended priority queue of up to CAPACITY signed 32-bit keys. Each input beat is an
// insert, a remove-maximum or a remove-minimum (kind in in_tuser, key in in_tdata). One
// operation is accepted per clock cycle as long as a waiting result is not held back by
// out_tready; while the output register holds a result that is not taken, the input is
// stalled. The state update finishes in the accepting cycle and the result, if any, appears
// in the next cycle from the output register. The rate is set by the compare-and-shift in
// every cell, done in the accepting cycle: the keys are held twice, in an ascending and a
// descending sorted chain of CAPACITY cells, so both the minimum and the maximum sit in a
// fixed head cell. Inserts give no result unless the queue is full (status overflow); a
// remove on an empty queue returns 0 with status empty; kind 3 is ignored. No clearing
// pass is needed after reset.
module double_ended_priority_queue_unit
  import depq_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // key
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value
  output logic [1:0]  out_tuser   // status
);

  logic                    accept;
  logic signed [KEY_W-1:0] ins_key;
  op_t                     asc_op;
  op_t                     desc_op;
  logic signed [KEY_W-1:0] asc_head_key;
  logic signed [KEY_W-1:0] desc_head_key;
  logic                    asc_head_occ;
  logic                    asc_tail_occ;
  logic                    desc_head_occ;
  logic                    desc_tail_occ;
  logic                    has_result;
  logic [KEY_W-1:0]        res_value;
  logic [1:0]              res_status;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [KEY_W-1:0]        out_value_r;
  logic [1:0]              out_status_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign ins_key   = $signed(in_tdata);

  always_comb begin
    asc_op     = OP_HOLD;
    desc_op    = OP_HOLD;
    has_result = 1'b0;
    res_value  = '0;
    res_status = STATUS_REMOVED;
    if (accept) begin
      unique case (in_tuser)
        KIND_INSERT: begin
          if (asc_tail_occ || desc_tail_occ) begin
            has_result = 1'b1;
            res_status = STATUS_OVERFLOW;
          end else begin
            asc_op  = OP_INSERT;
            desc_op = OP_INSERT;
          end
        end
        KIND_REMOVE_MAX: begin
          has_result = 1'b1;
          if (!desc_head_occ) begin
            res_status = STATUS_EMPTY;
          end else begin
            asc_op    = OP_POP_BACK;
            desc_op   = OP_POP_FRONT;
            res_value = desc_head_key;
          end
        end
        KIND_REMOVE_MIN: begin
          has_result = 1'b1;
          if (!asc_head_occ) begin
            res_status = STATUS_EMPTY;
          end else begin
            asc_op    = OP_POP_FRONT;
            desc_op   = OP_POP_BACK;
            res_value = asc_head_key;
          end
        end
        default: begin
        end
      endcase
    end
  end

  depq_chain #(
    .CAPACITY(CAPACITY),
    .DESCEND (1'b0)
  ) u_asc (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (asc_op),
    .ins_key (ins_key),
    .head_key(asc_head_key),
    .head_occ(asc_head_occ),
    .tail_occ(asc_tail_occ)
  );

  // mirror copy, largest key at the head
  depq_chain #(
    .CAPACITY(CAPACITY),
    .DESCEND (1'b1)
  ) u_desc (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (desc_op),
    .ins_key (ins_key),
    .head_key(desc_head_key),
    .head_occ(desc_head_occ),
    .tail_occ(desc_tail_occ)
  );

  always_comb begin
    if (accept && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

endmodule

>>> hw/rtl/depq_cell.sv
module depq_cell
  import depq_pkg::*;
#(
  parameter bit DESCEND = 1'b0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  op_t                     op,
  input  logic signed [KEY_W-1:0] ins_key,
  input  link_t                   left_i,
  input  link_t                   right_i,
  output link_t                   self_o
);

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;
  logic                    occ_r;
  logic                    occ_nxt;
  logic                    beyond;

  // an empty cell sorts after every key
  always_comb begin
    if (DESCEND) begin
      beyond = !occ_r || (key_r < ins_key);
    end else begin
      beyond = !occ_r || (key_r > ins_key);
    end
  end

  always_comb begin
    key_nxt = key_r;
    occ_nxt = occ_r;
    unique case (op)
      OP_INSERT: begin
        if (beyond) begin
          occ_nxt = occ_r | left_i.occ;
          key_nxt = left_i.beyond ? left_i.key : ins_key;
        end
      end
      OP_POP_FRONT: begin
        key_nxt = right_i.key;
        occ_nxt = right_i.occ;
      end
      OP_POP_BACK: begin
        occ_nxt = right_i.occ;
      end
      OP_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign self_o.key    = key_r;
  assign self_o.occ    = occ_r;
  assign self_o.beyond = beyond;

endmodule

>>> hw/rtl/depq_chain.sv
module depq_chain
  import depq_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter bit DESCEND  = 1'b0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  op_t                     op,
  input  logic signed [KEY_W-1:0] ins_key,
  output logic signed [KEY_W-1:0] head_key,
  output logic                    head_occ,
  output logic                    tail_occ
);

  link_t links [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t left_l;
    link_t right_l;

    if (i == 0) begin : g_first
      assign left_l = '{key: '0, occ: 1'b1, beyond: 1'b0};
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_l = '{key: '0, occ: 1'b0, beyond: 1'b1};
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end

    depq_cell #(
      .DESCEND(DESCEND)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .op     (op),
      .ins_key(ins_key),
      .left_i (left_l),
      .right_i(right_l),
      .self_o (links[i])
    );
  end

  assign head_key = links[0].key;
  assign head_occ = links[0].occ;
  assign tail_occ = links[CAPACITY-1].occ;

endmodule

>>> tb/sv/double_ended_priority_queue_unit_tb.sv
module double_ended_priority_queue_unit_tb;
  import depq_pkg::*;

  localparam int          FILL_CAP    = 256;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
  } depq_op_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } depq_reply_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  depq_op_t          op_backlog[$];
  depq_reply_t       replies_due[$];
  logic signed [31:0] sorted_keys[$];

  int send_gap_max  = 8;
  int take_gap_max  = 8;
  bit hold_receiver = 1'b0;
  int send_gap      = 0;
  int take_gap      = 0;

  int mismatches    = 0;
  int n_inserts     = 0;
  int n_take_max    = 0;
  int n_take_min    = 0;
  int n_ignored     = 0;
  int n_empty       = 0;
  int n_dropped     = 0;
  int peak_fill     = 0;

  double_ended_priority_queue_unit #(
    .CAPACITY(FILL_CAP)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic void run_depq_op(logic [1:0] kind, logic signed [31:0] key);
    depq_reply_t r;
    int pos;
    r.value  = '0;
    r.status = STATUS_REMOVED;
    case (kind)
      KIND_INSERT: begin
        n_inserts++;
        if (sorted_keys.size() >= FILL_CAP) begin
          r.status = STATUS_OVERFLOW;
          n_dropped++;
          replies_due.push_back(r);
        end else begin
          pos = sorted_keys.size();
          while (pos > 0 && sorted_keys[pos-1] > key) pos--;
          sorted_keys.insert(pos, key);
          if (sorted_keys.size() > peak_fill) peak_fill = sorted_keys.size();
        end
      end
      KIND_REMOVE_MAX, KIND_REMOVE_MIN: begin
        if (kind == KIND_REMOVE_MAX) n_take_max++;
        else n_take_min++;
        if (sorted_keys.size() == 0) begin
          r.status = STATUS_EMPTY;
          n_empty++;
        end else if (kind == KIND_REMOVE_MAX) begin
          r.value = sorted_keys.pop_back();
        end else begin
          r.value = sorted_keys.pop_front();
        end
        replies_due.push_back(r);
      end
      default: n_ignored++;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(logic [1:0] kind, logic [31:0] key);
    depq_op_t op;
    op.kind = kind;
    op.key  = key;
    op_backlog.push_back(op);
  endtask

  task automatic push_random_ops(int count, int insert_pct);
    int roll;
    logic [1:0] kind;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) kind = KIND_UNUSED;
      else if (roll < 4 + insert_pct) kind = KIND_INSERT;
      else if (roll[0]) kind = KIND_REMOVE_MAX;
      else kind = KIND_REMOVE_MIN;
      push_op(kind, pick_key());
    end
  endtask

  task automatic drain_ops();
    do @(negedge clk);
    while (op_backlog.size() != 0 || in_tvalid || replies_due.size() != 0);
  endtask

  // sender
  always @(posedge clk) begin
    depq_op_t op;
    logic offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        run_depq_op(in_tuser, in_tdata);
        send_gap = $urandom_range(0, send_gap_max);
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (op_backlog.size() != 0) begin
          op = op_backlog.pop_front();
          offer = 1'b1;
          in_tuser <= op.kind;
          in_tdata <= op.key;
        end
      end
      in_tvalid <= offer;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    depq_reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: value %h status %0d", out_tdata, out_tuser);
        end else begin
          want = replies_due.pop_front();
          if (out_tdata !== want.value || out_tuser !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("wrong beat: value %h status %0d, wanted value %h status %0d",
                       out_tdata, out_tuser, want.value, want.status);
          end
        end
        take_gap = $urandom_range(0, take_gap_max);
      end
      if (hold_receiver) begin
        out_tready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue, unused kind, extreme and duplicate keys
    push_op(KIND_REMOVE_MAX, 32'h1234_5678);
    push_op(KIND_REMOVE_MIN, 32'hffff_ffff);
    push_op(KIND_UNUSED, 32'h0000_0005);
    push_op(KIND_INSERT, 32'h7fff_ffff);
    push_op(KIND_INSERT, 32'h8000_0000);
    push_op(KIND_INSERT, 32'h0000_0000);
    push_op(KIND_INSERT, 32'hffff_ffff);
    push_op(KIND_INSERT, 32'h0000_0001);
    push_op(KIND_INSERT, 32'h0000_0000);
    push_op(KIND_INSERT, 32'h5555_5555);
    push_op(KIND_INSERT, 32'haaaa_aaaa);
    push_op(KIND_UNUSED, 32'h8000_0000);
    push_op(KIND_REMOVE_MIN, 32'h0);
    push_op(KIND_REMOVE_MAX, 32'h0);
    push_op(KIND_REMOVE_MIN, 32'h0);
    push_op(KIND_REMOVE_MAX, 32'h0);
    push_op(KIND_REMOVE_MIN, 32'h0);
    push_op(KIND_REMOVE_MIN, 32'h0);
    push_op(KIND_REMOVE_MAX, 32'h0);
    push_op(KIND_REMOVE_MAX, 32'h0);
    push_op(KIND_REMOVE_MIN, 32'h0);
    drain_ops();

    // fill to capacity, overflow, then empty it from both ends
    send_gap_max = 0;
    take_gap_max = 4;
    for (int i = 0; i < FILL_CAP + 4; i++) push_op(KIND_INSERT, pick_key());
    for (int i = 0; i < FILL_CAP + 2; i++)
      push_op($urandom_range(0, 1) ? KIND_REMOVE_MAX : KIND_REMOVE_MIN, $urandom);
    drain_ops();

    send_gap_max = 8;
    take_gap_max = 8;
    push_random_ops(270, 50);
    drain_ops();

    send_gap_max = 0;
    take_gap_max = 0;
    push_random_ops(270, 70);
    drain_ops();

    // receiver stalls for a long stretch while operations keep coming
    hold_receiver = 1'b1;
    push_random_ops(60, 40);
    repeat (400) @(negedge clk);
    hold_receiver = 1'b0;
    drain_ops();

    send_gap_max = 0;
    take_gap_max = 8;
    push_random_ops(270, 75);
    drain_ops();

    send_gap_max = 8;
    take_gap_max = 0;
    push_random_ops(270, 25);
    drain_ops();

    repeat (20) @(negedge clk);
    $display("ran %0d inserts, %0d max removals, %0d min removals, %0d ignored ops",
             n_inserts, n_take_max, n_take_min, n_ignored);
    $display("%0d removals on empty, %0d inserts dropped when full, peak fill %0d of %0d",
             n_empty, n_dropped, peak_fill, FILL_CAP);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("double_ended_priority_queue_unit: match");
    end else begin
      $display("double_ended_priority_queue_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d beats outstanding", replies_due.size());
    $display("double_ended_priority_queue_unit: mismatch");
    $finish;
  end

endmodule
